FILE: rtl/serial_value_link_relay_assert.svh
// Assertion macros for the serial value link relay.
// Included by files that check their own logic; no other dependencies.
`ifndef SERIAL_VALUE_LINK_RELAY_ASSERT_SVH
`define SERIAL_VALUE_LINK_RELAY_ASSERT_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define SVLR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SVLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SVLR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SVLR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/svlr_pkg.sv
// Shared types and constants of the serial value link relay.
// No dependencies; used by the top level and by svlr_out.
package svlr_pkg;

  // Opcode carried in s_tuser
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] CFG_SEND_PERIOD  = 8'd0;
  localparam logic [7:0] CFG_FRESH_WINDOW = 8'd1;

  localparam logic [15:0] SEND_PERIOD_RST  = 16'd50;
  localparam logic [15:0] FRESH_WINDOW_RST = 16'd150;

  // Link bytes
  localparam logic [7:0] ACK_BYTE = 8'd128;
  localparam logic [7:0] REQ_BYTE = 8'd131;

  localparam int BUNDLE_MAX = 3;

  // Up to three transmit beats produced by one input item
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } svlr_bundle_t;

endpackage

FILE: rtl/serial_value_link_relay.sv
// Serial value link relay, top level; uses svlr_pkg, svlr_chan, svlr_out.
// An accepted beat is registered in the input register and decoded from there;
// its transmit beats are then loaded into the svlr_out register, which drives m_tdata.
// Throughput: one item per cycle while no item with beats waits on the output register;
// a transmitting tick sends one beat (three with a grant), so that port sets the pace.
// Reset (rst, synchronous): handshake state, counters and filters cleared, config to defaults.
`include "serial_value_link_relay_assert.svh"

module serial_value_link_relay #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic [0:0]  s_tuser,    // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] tx_byte
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDXW = $clog2(CHANNELS);

  // Configuration registers
  logic [15:0] send_period;
  logic [15:0] fresh_window;

  // Input register
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;

  // Link state
  logic        armed;
  logic        requested;
  logic        granted;
  logic [6:0]  expected;
  logic [6:0]  received;
  logic [15:0] send_elapsed;
  logic [15:0] since_msg;
  logic [CHANNELS-1:0][6:0] staging;

  // Decode of the item in the input register
  logic        is_tick;
  logic        is_ack;
  logic        is_hdr;
  logic        is_data;
  logic [6:0]  received_next;
  logic        stage_wr;
  logic        commit_all;
  logic [15:0] since_inc;
  logic [16:0] elapsed_inc;
  logic        send_due;
  logic        fresh;
  logic [1:0]  n_beats;
  logic        proceed;
  logic        can_load;
  logic        out_load;
  svlr_pkg::svlr_bundle_t bundle;
  logic [CHANNELS-1:0][6:0] codes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      send_period  <= svlr_pkg::SEND_PERIOD_RST;
      fresh_window <= svlr_pkg::FRESH_WINDOW_RST;
    end else if (cfg_valid) begin
      // Drop writes to indexes beyond the register list
      if (cfg_index == svlr_pkg::CFG_SEND_PERIOD) begin
        send_period <= cfg_data;
      end else if (cfg_index == svlr_pkg::CFG_FRESH_WINDOW) begin
        fresh_window <= cfg_data;
      end
    end
  end

  // Decode: header bytes carry a count, the bare ack grants a pending request,
  // 7-bit bytes are data only while a message is open.
  assign is_tick = (in_op == svlr_pkg::OP_TICK);
  assign is_ack  = !is_tick && (in_byte == svlr_pkg::ACK_BYTE);
  assign is_hdr  = !is_tick && in_byte[7] && (in_byte[6:0] != 7'd0);
  assign is_data = !is_tick && !in_byte[7] && armed;

  assign received_next = received + 7'd1;
  assign stage_wr      = is_data && (32'(received) < CHANNELS);
  assign commit_all    = is_data && (received_next >= expected);

  // Tick timing: the send period has to be exceeded, not just reached
  assign since_inc   = (since_msg == 16'hFFFF) ? since_msg : since_msg + 16'd1;
  assign elapsed_inc = {1'b0, send_elapsed} + 17'd1;
  assign send_due    = is_tick && (elapsed_inc > {1'b0, send_period});
  assign fresh       = since_inc < fresh_window;

  always_comb begin
    if (is_hdr) begin
      n_beats = 2'd1;
    end else if (send_due) begin
      n_beats = granted ? 2'd3 : 2'd1;
    end else begin
      n_beats = 2'd0;
    end
  end

  // Advance the input register only when its beats fit the output register
  assign proceed  = in_valid && ((n_beats == 2'd0) || can_load);
  assign out_load = proceed && (n_beats != 2'd0);
  assign s_tready = !in_valid || proceed;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  // Result beats for the item under decode
  always_comb begin
    bundle.count = n_beats;
    bundle.bytes = '0;
    if (is_hdr) begin
      bundle.bytes[0] = svlr_pkg::ACK_BYTE;
    end else if (granted) begin
      bundle.bytes[0] = {1'b0, codes[0]};
      bundle.bytes[1] = {1'b0, codes[1]};
      bundle.bytes[2] = {1'b0, codes[3]};
    end else begin
      bundle.bytes[0] = svlr_pkg::REQ_BYTE;
    end
  end

  // Link state update
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= 1'b0;
      requested    <= 1'b0;
      granted      <= 1'b0;
      expected     <= '0;
      received     <= '0;
      send_elapsed <= '0;
      since_msg    <= '0;
    end else if (proceed) begin
      if (is_tick) begin
        since_msg <= since_inc;
        if (send_due) begin
          send_elapsed <= '0;
          // Hold a request pending until the peer acks; a grant lasts one send
          requested    <= !granted;
          granted      <= 1'b0;
        end else begin
          send_elapsed <= elapsed_inc[15:0];
        end
      end else if (is_ack) begin
        if (requested) begin
          granted   <= 1'b1;
          requested <= 1'b0;
        end
      end else if (in_byte[7]) begin
        // Header byte with a nonzero count; a zero count is the ack byte, decoded above
        expected <= in_byte[6:0];
        received <= '0;
        armed    <= (in_byte[6:0] != 7'd0);
      end else if (is_data) begin
        if (commit_all) begin
          armed     <= 1'b0;
          expected  <= '0;
          received  <= '0;
          since_msg <= '0;
        end else begin
          received <= received_next;
        end
      end
    end
  end

  // Staging store: written entries only ever get committed
  always_ff @(posedge clk) begin
    if (proceed && stage_wr) begin
      staging[received[IDXW-1:0]] <= in_byte[6:0];
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    logic       ch_commit;
    logic [6:0] ch_val;

    // The closing data beat lands in staging and is committed in the same cycle
    assign ch_commit = proceed && commit_all && (7'(i) < received_next);
    assign ch_val    = (stage_wr && (32'(received) == i)) ? in_byte[6:0] : staging[i];

    svlr_chan u_chan (
      .clk        (clk),
      .rst        (rst),
      .commit     (ch_commit),
      .commit_val (ch_val),
      .update     (proceed && send_due && fresh),
      .code       (codes[i])
    );
  end

  svlr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .bundle   (bundle),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Request and grant never stand together
  `SVLR_ASSERT_NOW(a_req_gnt_excl, clk, rst, 1'b1, !(requested && granted))
  // A transmitting tick always uses up the grant
  `SVLR_ASSERT_NEXT(a_grant_used, clk, rst, proceed && send_due, !granted)
  // A stalled item stays in the input register
  `SVLR_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !proceed, in_valid)
  // Beats of one item run back to back: a non-last beat taken leaves more behind
  `SVLR_ASSERT_NEXT(a_bundle_cont, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

FILE: rtl/svlr_chan.sv
// One channel: committed value, Q2.16 averaging filter and 7-bit code.
// Depends on nothing but the clock and reset.
module svlr_chan (
  input  logic       clk,
  input  logic       rst,
  input  logic       commit,
  input  logic [6:0] commit_val,
  input  logic       update,
  output logic [6:0] code
);

  logic [6:0]  value;
  logic [17:0] filt;
  logic [17:0] conv;
  logic [20:0] frac_prod;
  logic [18:0] sum;
  logic [17:0] filt_next;
  logic [17:0] filt_now;
  logic [23:0] pos_prod;
  logic [17:0] mag;
  logic [7:0]  neg_q;

  // Value to Q2.16: v*65536/63 for v >= 0, split as 1040*v + floor(16*v/63)
  assign frac_prod = 21'(value[5:0]) * 21'd16656;
  always_comb begin
    if (value[6]) begin
      conv = {value[6], value, 10'd0};
    end else begin
      conv = 18'(value[5:0]) * 18'd1040 + 18'(frac_prod[20:16]);
    end
  end

  assign sum       = {filt[17], filt} + {conv[17], conv};
  assign filt_next = sum[18:1];
  assign filt_now  = update ? filt_next : filt;

  // Code from the filter: f*63/65536 when positive, -trunc(|f|/1024) otherwise
  assign pos_prod = {6'd0, filt_now} * 24'd63;
  assign mag      = -filt_now;
  assign neg_q    = mag[17:10];

  always_comb begin
    if (!filt_now[17]) begin
      code = (pos_prod[23:16] > 8'd63) ? 7'd63 : pos_prod[22:16];
    end else if (neg_q >= 8'd64) begin
      code = 7'h40;
    end else begin
      code = 7'(-neg_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      filt  <= '0;
    end else begin
      if (commit) begin
        value <= commit_val;
      end
      if (update) begin
        filt <= filt_next;
      end
    end
  end

endmodule

FILE: rtl/svlr_out.sv
// Output register for the transmit stream: holds up to three beats of one item.
// Uses svlr_pkg::svlr_bundle_t.
module svlr_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  svlr_pkg::svlr_bundle_t bundle,
  output logic                  can_load,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,  // [7:0] tx_byte
  output logic                  m_tlast
);

  logic [2:0][7:0] beats;
  logic [1:0]      cnt;
  logic [1:0]      rd;
  logic            take;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tlast  = (rd == cnt - 2'd1);
  assign take     = m_tvalid && m_tready;
  assign can_load = !m_tvalid || (take && m_tlast);

  always_comb begin
    case (rd)
      2'd0:    m_tdata = beats[0];
      2'd1:    m_tdata = beats[1];
      default: m_tdata = beats[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (load) begin
      cnt <= bundle.count;
      rd  <= '0;
    end else if (take && m_tlast) begin
      cnt <= '0;
      rd  <= '0;
    end else if (take) begin
      rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beats <= bundle.bytes;
    end
  end

endmodule
